### hdl/cba_pkg.sv
package cba_pkg;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  localparam logic [31:0] EXP_SIZE_RESET = 32'd16777216;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_CHUNK_FULL = 2'd1,
    ST_RES_FULL   = 2'd2,
    ST_BAD_INDEX  = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] new_chunk_size;
    logic        new_chunk;
    logic [31:0] placed_offset;
    logic [7:0]  slot_in_chunk;
    logic [3:0]  chunk_index;
    logic [7:0]  resource_index;
    status_e     status;
  } res_t;

endpackage

### hdl/cba_ram.sv
module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/cba_engine.sv
module cba_engine import cba_pkg::*; #(
  parameter int MAX_CHUNKS    = 16,
  parameter int MAX_RESOURCES = 256,
  parameter int ALIGN_LOG2    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] req_size_i,
  input  logic [7:0]  req_look_i,
  input  logic [31:0] exp_size_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);

  localparam int CW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CCW  = $clog2(MAX_CHUNKS + 1);
  localparam int RW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int RCW  = $clog2(MAX_RESOURCES + 1);
  localparam int CMPW = (RCW > 8) ? RCW : 8;
  localparam int PKW  = (CW > 4) ? CW : 4;
  localparam int CHW  = 72;
  localparam int RECW = CW + 8;
  localparam logic [33:0] AMASK = (34'd1 << ALIGN_LOG2) - 34'd1;

  typedef struct packed {
    logic [31:0] bytes;
    logic [31:0] used;
    logic [7:0]  recs;
  } chunk_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_NEW, S_BUMP, S_LOOK, S_RESP
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     pick_q, pick_d;
  logic [31:0]       size_q, size_d;
  logic [7:0]        look_q, look_d;
  logic [31:0]       bytes_q, bytes_d;
  logic [31:0]       used_q, used_d;
  logic [7:0]        recs_q, recs_d;
  logic              isnew_q, isnew_d;
  logic [CCW-1:0]    chunk_cnt_q, chunk_cnt_d;
  logic [RCW-1:0]    rec_cnt_q, rec_cnt_d;
  logic [MAX_CHUNKS-1:0] clr_q, clr_d;
  res_t              res_q, res_d;

  logic              ch_we, ch_re;
  logic [CW-1:0]     ch_waddr, ch_raddr;
  chunk_t            ch_wdata, ch_rdata;
  logic              rc_we, rc_re;
  logic [RW-1:0]     rc_waddr, rc_raddr;
  logic [RECW-1:0]   rc_wdata, rc_rdata;

  logic [31:0]       used_eff;
  logic [7:0]        recs_eff;
  logic              fit;
  logic [33:0]       bump_sum, bump_al;
  logic [31:0]       bump;
  logic [CMPW-1:0]   look_ext, cnt_ext;
  logic [PKW-1:0]    pick_ext, rchunk_ext;

  cba_ram #(.WIDTH(CHW), .DEPTH(MAX_CHUNKS)) u_chunk_ram (
    .clk_i  (clk_i),
    .we_i   (ch_we),
    .waddr_i(ch_waddr),
    .wdata_i(ch_wdata),
    .re_i   (ch_re),
    .raddr_i(ch_raddr),
    .rdata_o(ch_rdata)
  );

  cba_ram #(.WIDTH(RECW), .DEPTH(MAX_RESOURCES)) u_rec_ram (
    .clk_i  (clk_i),
    .we_i   (rc_we),
    .waddr_i(rc_waddr),
    .wdata_i(rc_wdata),
    .re_i   (rc_re),
    .raddr_i(rc_raddr),
    .rdata_o(rc_rdata)
  );

  // a cleared chunk reads as empty until it is next written
  assign used_eff = clr_q[idx_q] ? 32'd0 : ch_rdata.used;
  assign recs_eff = clr_q[idx_q] ? 8'd0 : ch_rdata.recs;
  assign fit      = (ch_rdata.bytes - used_eff) >= size_q;

  assign bump_sum = {2'b00, used_q} + {2'b00, size_q} + AMASK;
  assign bump_al  = bump_sum & ~AMASK;
  assign bump     = (bump_al > {2'b00, bytes_q}) ? bytes_q : bump_al[31:0];

  assign look_ext   = CMPW'(req_look_i);
  assign cnt_ext    = CMPW'(rec_cnt_q);
  assign pick_ext   = PKW'(pick_q);
  assign rchunk_ext = PKW'(rc_rdata[RECW-1:8]);

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pick_d      = pick_q;
    size_d      = size_q;
    look_d      = look_q;
    bytes_d     = bytes_q;
    used_d      = used_q;
    recs_d      = recs_q;
    isnew_d     = isnew_q;
    chunk_cnt_d = chunk_cnt_q;
    rec_cnt_d   = rec_cnt_q;
    clr_d       = clr_q;
    res_d       = res_q;
    ch_we       = 1'b0;
    ch_re       = 1'b0;
    ch_waddr    = pick_q;
    ch_raddr    = idx_q;
    ch_wdata    = '{bytes: bytes_q, used: bump, recs: recs_q + 8'd1};
    rc_we       = 1'b0;
    rc_re       = 1'b0;
    rc_waddr    = rec_cnt_q[RW-1:0];
    rc_raddr    = look_ext[RW-1:0];
    rc_wdata    = {pick_q, recs_q};

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          size_d  = req_size_i;
          look_d  = req_look_i;
          isnew_d = 1'b0;
          res_d   = '0;
          state_d = S_RESP;
          case (req_type_i)
            REQ_ALLOC: begin
              if (rec_cnt_q >= RCW'(MAX_RESOURCES)) begin
                res_d.status = ST_RES_FULL;
              end else if (chunk_cnt_q == '0) begin
                state_d = S_NEW;
              end else begin
                ch_re    = 1'b1;
                ch_raddr = '0;
                idx_d    = '0;
                state_d  = S_CHK;
              end
            end
            REQ_CLEAR: begin
              clr_d     = '1;
              rec_cnt_d = '0;
            end
            REQ_LOOKUP: begin
              if (look_ext >= cnt_ext) begin
                res_d.status = ST_BAD_INDEX;
              end else begin
                rc_re   = 1'b1;
                state_d = S_LOOK;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        // data of chunk idx_q is here; on a miss, fetch the next one meanwhile
        if (fit) begin
          pick_d  = idx_q;
          bytes_d = ch_rdata.bytes;
          used_d  = used_eff;
          recs_d  = recs_eff;
          state_d = S_BUMP;
        end else if (CCW'(idx_q) + CCW'(1) == chunk_cnt_q) begin
          state_d = S_NEW;
        end else begin
          ch_re    = 1'b1;
          ch_raddr = idx_q + CW'(1);
          idx_d    = idx_q + CW'(1);
        end
      end
      S_NEW: begin
        if (chunk_cnt_q >= CCW'(MAX_CHUNKS)) begin
          res_d.status = ST_CHUNK_FULL;
          state_d      = S_RESP;
        end else begin
          pick_d  = chunk_cnt_q[CW-1:0];
          bytes_d = (exp_size_i > size_q) ? exp_size_i : size_q;
          used_d  = '0;
          recs_d  = '0;
          isnew_d = 1'b1;
          state_d = S_BUMP;
        end
      end
      S_BUMP: begin
        ch_we         = 1'b1;
        rc_we         = 1'b1;
        clr_d[pick_q] = 1'b0;
        rec_cnt_d     = rec_cnt_q + RCW'(1);
        if (isnew_q) begin
          chunk_cnt_d = chunk_cnt_q + CCW'(1);
        end
        res_d.resource_index = cnt_ext[7:0];
        res_d.chunk_index    = pick_ext[3:0];
        res_d.slot_in_chunk  = recs_q;
        res_d.placed_offset  = used_q;
        res_d.new_chunk      = isnew_q;
        res_d.new_chunk_size = isnew_q ? bytes_q : 32'd0;
        res_d.status         = ST_OK;
        state_d              = S_RESP;
      end
      S_LOOK: begin
        res_d.resource_index = look_q;
        res_d.chunk_index    = rchunk_ext[3:0];
        res_d.slot_in_chunk  = rc_rdata[7:0];
        state_d              = S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chunk_cnt_q <= '0;
      rec_cnt_q   <= '0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      chunk_cnt_q <= chunk_cnt_d;
      rec_cnt_q   <= rec_cnt_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pick_q  <= pick_d;
    size_q  <= size_d;
    look_q  <= look_d;
    bytes_q <= bytes_d;
    used_q  <= used_d;
    recs_q  <= recs_d;
    isnew_q <= isnew_d;
    res_q   <= res_d;
  end

endmodule

### hdl/chunked_bump_allocator_unit.sv
// First-fit chunked bump allocator.
// Requests enter on the s_axis channel: tuser carries the request type
// (allocate, clear, look up), tdata the byte size and the lookup index.
// Every request gives exactly one result on the m_axis channel; tuser
// carries the status, tdata the placement fields.
// The minimum size of a newly opened chunk is written on the cfg channel,
// which is always ready; write it only while no request is in flight.
// One request is handled at a time. An allocate scans the chunk memory one
// chunk per cycle from chunk 0 and takes the first that fits; on a miss it
// opens a new chunk or reports a full chunk table. Clear, unused and
// resource-full requests need no memory access; a lookup in range first
// reads the record memory. The next request is accepted as soon as the
// result has moved into the output register, even while the receiver
// stalls; a second result then waits until the first is taken.
// Reset empties the chunk and record tables and sets the minimum chunk size
// to 16 MiB; the memories need no clearing pass.
module chunked_bump_allocator_unit import cba_pkg::*; #(
  parameter int MAX_CHUNKS    = 16,
  parameter int MAX_RESOURCES = 256,
  parameter int ALIGN_LOG2    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // required_size, lookup_index
  input  logic [1:0]  s_axis_tuser_i,  // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // resource_index, chunk_index, slot_in_chunk, placed_offset, new_chunk,
  // new_chunk_size, zero padding
  output logic [87:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,  // status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] exp_size_q;
  logic        res_valid, res_ready;
  res_t        res;
  logic        out_valid_q;
  res_t        out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_size_q <= EXP_SIZE_RESET;
    end else if (cfg_valid_i) begin
      exp_size_q <= cfg_data_i;
    end
  end

  cba_engine #(
    .MAX_CHUNKS   (MAX_CHUNKS),
    .MAX_RESOURCES(MAX_RESOURCES),
    .ALIGN_LOG2   (ALIGN_LOG2)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid_i),
    .req_ready_o(s_axis_tready_o),
    .req_type_i (s_axis_tuser_i),
    .req_size_i (s_axis_tdata_i[31:0]),
    .req_look_i (s_axis_tdata_i[39:32]),
    .exp_size_i (exp_size_q),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // take a new result whenever the output register is empty or draining
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {3'b000, out_q.new_chunk_size, out_q.new_chunk,
                            out_q.placed_offset, out_q.slot_in_chunk,
                            out_q.chunk_index, out_q.resource_index};

endmodule

### tb/chunked_bump_allocator_unit_tb.sv
module chunked_bump_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cba_pkg::*;

  localparam int NCHUNK = 16;
  localparam int NREC = 256;
  localparam logic [63:0] ALIGN_MASK = (64'd1 << 16) - 64'd1;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    bit          wr_cfg;
    logic [1:0]  kind;
    logic [31:0] size;
    logic [7:0]  idx;
    bit          typed;
    res_t        want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [87:0] m_tdata;
  wire  [1:0]  m_tuser;
  wire         cfg_ready;

  // allocator state as predicted
  logic [31:0] min_chunk_size;
  logic [31:0] chunk_size_m [NCHUNK];
  logic [31:0] chunk_fill_m [NCHUNK];
  int          chunk_recs_m [NCHUNK];
  int          open_chunks;
  logic [3:0]  rec_chunk_m [NREC];
  logic [7:0]  rec_slot_m [NREC];
  int          rec_total;

  res_t        placements_due [$];
  int          mismatches = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          rx_hold = 0;
  int          until_clear = 0;

  chunked_bump_allocator_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic res_t status_only(status_e st);
    res_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic script_row_t mk_row(bit wr, logic [1:0] k, logic [31:0] s,
                                         logic [7:0] i, bit typed, res_t want);
    script_row_t row;
    row.wr_cfg = wr;
    row.kind = k;
    row.size = s;
    row.idx = i;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  // Work out the placement for one accepted request and advance the state.
  function automatic res_t place_request(logic [1:0] k, logic [31:0] s, logic [7:0] i);
    res_t r;
    logic [63:0] bump;
    int pick;
    int c;
    r = '0;
    r.status = ST_OK;
    case (k)
      REQ_ALLOC: begin
        pick = -1;
        for (c = 0; c < open_chunks; c++)
          if (pick < 0 && chunk_size_m[c] - chunk_fill_m[c] >= s) pick = c;
        if (rec_total >= NREC) begin
          r.status = ST_RES_FULL;
        end else if (pick < 0 && open_chunks >= NCHUNK) begin
          r.status = ST_CHUNK_FULL;
        end else begin
          if (pick < 0) begin
            pick = open_chunks;
            chunk_size_m[pick] = (min_chunk_size > s) ? min_chunk_size : s;
            chunk_fill_m[pick] = '0;
            chunk_recs_m[pick] = 0;
            open_chunks++;
            r.new_chunk = 1'b1;
            r.new_chunk_size = chunk_size_m[pick];
          end
          r.placed_offset = chunk_fill_m[pick];
          // bump wide, then clamp to the chunk
          bump = ({32'd0, chunk_fill_m[pick]} + {32'd0, s} + ALIGN_MASK) & ~ALIGN_MASK;
          if (bump > {32'd0, chunk_size_m[pick]}) bump = {32'd0, chunk_size_m[pick]};
          chunk_fill_m[pick] = bump[31:0];
          r.resource_index = rec_total[7:0];
          r.chunk_index = pick[3:0];
          r.slot_in_chunk = chunk_recs_m[pick][7:0];
          rec_chunk_m[rec_total] = pick[3:0];
          rec_slot_m[rec_total] = chunk_recs_m[pick][7:0];
          chunk_recs_m[pick]++;
          rec_total++;
        end
      end
      REQ_CLEAR: begin
        for (c = 0; c < NCHUNK; c++) begin
          chunk_fill_m[c] = '0;
          chunk_recs_m[c] = 0;
        end
        rec_total = 0;
      end
      REQ_LOOKUP: begin
        if (int'(i) >= rec_total) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.resource_index = i;
          r.chunk_index = rec_chunk_m[i];
          r.slot_in_chunk = rec_slot_m[i];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_req(logic [1:0] k, logic [31:0] s, logic [7:0] i, bit typed,
                          res_t want);
    res_t predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {i, s};
    s_tuser <= k;
    do @(posedge clk); while (!s_tready);
    predicted = place_request(k, s, i);
    placements_due.insert(placements_due.size(), typed ? want : predicted);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (placements_due.size() != 0);
  endtask

  task automatic write_min_chunk(logic [31:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    min_chunk_size = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_traffic(int n);
    logic [1:0] k;
    logic [31:0] s;
    logic [7:0] i;
    int pick;
    repeat (n) begin
      pick = $urandom_range(99);
      s = $urandom;
      i = 8'($urandom_range(255));
      if (until_clear == 0) begin
        k = REQ_CLEAR;
        until_clear = $urandom_range(20, 600);
      end else if (pick < 2) begin
        k = REQ_UNUSED;
      end else if (pick < 24) begin
        k = REQ_LOOKUP;
        if (rec_total > 0 && $urandom_range(99) < 80) i = 8'($urandom_range(0, rec_total - 1));
      end else begin
        k = REQ_ALLOC;
        pick = $urandom_range(99);
        if (pick < 45) s = $urandom_range(0, 32'h0002_0000);
        else if (pick < 60) s = $urandom_range(0, 15) << 16;
        else if (pick < 88) s = $urandom_range(0, 32'h00FF_FFFF);
        else if (pick < 95) s = $urandom;
        else s = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      end
      if (until_clear > 0) until_clear--;
      send_req(k, s, i, 1'b0, '0);
    end
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    res_t want;
    if (placements_due.size() == 0) begin
      $error("result with no request outstanding: tdata %0h tuser %0h", m_tdata, m_tuser);
      mismatches++;
    end else begin
      want = placements_due.pop_front();
      check_field("resource_index", want.resource_index, m_tdata[7:0]);
      check_field("chunk_index", want.chunk_index, m_tdata[11:8]);
      check_field("slot_in_chunk", want.slot_in_chunk, m_tdata[19:12]);
      check_field("placed_offset", want.placed_offset, m_tdata[51:20]);
      check_field("new_chunk", want.new_chunk, m_tdata[52]);
      check_field("new_chunk_size", want.new_chunk_size, m_tdata[84:53]);
      check_field("status", want.status, m_tuser);
    end
  endtask

  // receiver: take results, stall at random or for a counted hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) check_result();
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    script_row_t script [$];
    res_t opened;
    min_chunk_size = EXP_SIZE_RESET;
    open_chunks = 0;
    rec_total = 0;
    opened = '0;
    opened.new_chunk = 1'b1;
    opened.new_chunk_size = EXP_SIZE_RESET;

    script = {script, mk_row(0, REQ_LOOKUP, 32'h0, 8'd0, 1, status_only(ST_BAD_INDEX))};
    script = {script, mk_row(0, REQ_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1, status_only(ST_OK))};
    script = {script, mk_row(0, REQ_ALLOC, 32'h0, 8'h00, 1, opened)};
    script = {script, mk_row(0, REQ_ALLOC, 32'h1, 8'h00, 0, '0)};
    script = {script, mk_row(0, REQ_ALLOC, 32'h00FF_0000, 8'h00, 0, '0)};
    script = {script, mk_row(0, REQ_ALLOC, 32'h0, 8'h00, 0, '0)};
    // alignment bump past 2^32, clamped
    script = {script, mk_row(0, REQ_ALLOC, 32'hFFFF_FFFF, 8'h00, 0, '0)};
    script = {script, mk_row(0, REQ_LOOKUP, 32'h0, 8'd2, 0, '0)};
    script = {script, mk_row(0, REQ_LOOKUP, 32'h0, 8'd255, 1, status_only(ST_BAD_INDEX))};
    script = {script, mk_row(1, REQ_ALLOC, 32'd1, 8'h00, 0, '0)};
    script = {script, mk_row(0, REQ_ALLOC, 32'd5, 8'h00, 0, '0)};
    script = {script, mk_row(0, REQ_ALLOC, 32'h0, 8'h00, 0, '0)};
    script = {script, mk_row(0, REQ_CLEAR, 32'h0, 8'h00, 1, status_only(ST_OK))};
    script = {script, mk_row(0, REQ_LOOKUP, 32'h0, 8'd0, 1, status_only(ST_BAD_INDEX))};
    script = {script, mk_row(0, REQ_ALLOC, 32'hFFFF_FFFF, 8'h00, 0, '0)};
    script = {script, mk_row(1, REQ_ALLOC, 32'hFFFF_FFFF, 8'h00, 0, '0)};
    script = {script, mk_row(0, REQ_ALLOC, 32'h0200_0000, 8'h00, 0, '0)};
    script = {script, mk_row(0, REQ_LOOKUP, 32'h0, 8'd1, 0, '0)};
    script = {script, mk_row(1, REQ_ALLOC, EXP_SIZE_RESET, 8'h00, 0, '0)};
    script = {script, mk_row(0, REQ_ALLOC, 32'h0001_0000, 8'h00, 0, '0)};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 25;
    rx_idle_pct = 65;
    foreach (script[n]) begin
      if (script[n].wr_cfg) write_min_chunk(script[n].size);
      else send_req(script[n].kind, script[n].size, script[n].idx, script[n].typed,
                    script[n].want);
    end

    until_clear = $urandom_range(20, 600);
    write_min_chunk(32'h0008_0000);
    random_traffic(660);

    write_min_chunk($urandom_range(1, 32'hFFFF_FFFF));
    tx_idle_pct = 65;
    rx_idle_pct = 25;
    random_traffic(660);

    // stall the output long enough for the input to back up
    write_min_chunk(32'd1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold = 300;
    random_traffic(660);

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/cba_pkg.sv
hdl/cba_ram.sv
hdl/cba_engine.sv
hdl/chunked_bump_allocator_unit.sv
tb/chunked_bump_allocator_unit_tb.sv
